// ----- hdl/gtcr_pkg.sv -----
// gtcr_pkg: shared types and constants of the gamepad teleop command ramp block
// holds the register index codes, reset values, command bytes and the structs
// passed between the config, tick core and result stages; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package gtcr_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_DEADZONE  = 3'd0,
        REG_RAMP_STEP = 3'd1,
        REG_FWD_HI    = 3'd2,
        REG_FWD_LO    = 3'd3,
        REG_ROT_HI    = 3'd4,
        REG_ROT_LO    = 3'd5,
        REG_SIDE_HI   = 3'd6,
        REG_SIDE_LO   = 3'd7
    } t_reg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int DZ_W       = 7;
    localparam int SPEED_W    = 11;
    localparam int BTN_W      = 13;
    localparam int STICK_W    = 8;
    localparam int CMD_W      = 8;
    localparam int RELAY_W    = 4;
    localparam int HIST_W     = 5;
    localparam int IN_BITS    = 1 + BTN_W + 2 * STICK_W;
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;

    // register reset values
    localparam logic [DZ_W-1:0]    RST_DEADZONE  = 7'd100;
    localparam logic [SPEED_W-1:0] RST_RAMP_STEP = 11'd20;
    localparam logic [SPEED_W-1:0] RST_FWD_HI    = 11'd358;
    localparam logic [SPEED_W-1:0] RST_FWD_LO    = 11'd128;
    localparam logic [SPEED_W-1:0] RST_ROT_HI    = 11'd819;
    localparam logic [SPEED_W-1:0] RST_ROT_LO    = 11'd512;
    localparam logic [SPEED_W-1:0] RST_SIDE_HI   = 11'd512;
    localparam logic [SPEED_W-1:0] RST_SIDE_LO   = 11'd307;

    // slave command bytes
    localparam logic [CMD_W-1:0] CMD_NONE       = 8'h00;
    localparam logic [CMD_W-1:0] CMD_STOP       = 8'h53; // 'S'
    localparam logic [CMD_W-1:0] CMD_A          = 8'h41; // 'A'
    localparam logic [CMD_W-1:0] CMD_B          = 8'h42; // 'B'
    localparam logic [CMD_W-1:0] CMD_UP_FAST    = 8'h55; // 'U'
    localparam logic [CMD_W-1:0] CMD_UP_SLOW    = 8'h75; // 'u'
    localparam logic [CMD_W-1:0] CMD_DOWN_FAST  = 8'h44; // 'D'
    localparam logic [CMD_W-1:0] CMD_DOWN_SLOW  = 8'h64; // 'd'
    localparam logic [CMD_W-1:0] CMD_OPEN_FAST  = 8'h4F; // 'O'
    localparam logic [CMD_W-1:0] CMD_OPEN_SLOW  = 8'h6F; // 'o'
    localparam logic [CMD_W-1:0] CMD_CLOSE_FAST = 8'h43; // 'C'
    localparam logic [CMD_W-1:0] CMD_CLOSE_SLOW = 8'h63; // 'c'

    // button bit positions
    localparam int BTN_UP       = 0;
    localparam int BTN_DOWN     = 1;
    localparam int BTN_LEFT     = 2;
    localparam int BTN_RIGHT    = 3;
    localparam int BTN_L1       = 4;
    localparam int BTN_R1       = 5;
    localparam int BTN_R2       = 6;
    localparam int BTN_TRIANGLE = 7;
    localparam int BTN_CROSS    = 8;
    localparam int BTN_SHARE    = 9;
    localparam int BTN_OPTIONS  = 10;
    localparam int BTN_SQUARE   = 11;
    localparam int BTN_CIRCLE   = 12;

    // live configuration
    typedef struct packed {
        logic [DZ_W-1:0]    deadzone;
        logic [SPEED_W-1:0] ramp_step;
        logic [SPEED_W-1:0] fwd_hi;
        logic [SPEED_W-1:0] fwd_lo;
        logic [SPEED_W-1:0] rot_hi;
        logic [SPEED_W-1:0] rot_lo;
        logic [SPEED_W-1:0] side_hi;
        logic [SPEED_W-1:0] side_lo;
    } t_cfg;

    // one gamepad sample
    typedef struct packed {
        logic signed [STICK_W-1:0] left_stick_y;
        logic signed [STICK_W-1:0] right_stick_y;
        logic [BTN_W-1:0]          buttons;
        logic                      link_up;
    } t_in;

    // per tick commands and relay levels handed to the result stage
    typedef struct packed {
        logic [2:0][CMD_W-1:0] cmds;
        logic [1:0]            ncmd;
        logic [RELAY_W-1:0]    relays;
    } t_tick;

endpackage

`default_nettype wire

// ----- hdl/gtcr_cfg.sv -----
// gtcr_cfg: configuration register bank of the teleop command ramp block
// plain write port, one register per index; uses gtcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module gtcr_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_we,
    input  wire logic [gtcr_pkg::CFG_IDX_W-1:0] i_idx,
    input  wire logic [gtcr_pkg::CFG_DATA_W-1:0] i_data,
    output gtcr_pkg::t_cfg                      o_cfg
);
    import gtcr_pkg::*;

    t_cfg r_cfg;

    // register writes, reset to the default speed set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadzone  <= RST_DEADZONE;
            r_cfg.ramp_step <= RST_RAMP_STEP;
            r_cfg.fwd_hi    <= RST_FWD_HI;
            r_cfg.fwd_lo    <= RST_FWD_LO;
            r_cfg.rot_hi    <= RST_ROT_HI;
            r_cfg.rot_lo    <= RST_ROT_LO;
            r_cfg.side_hi   <= RST_SIDE_HI;
            r_cfg.side_lo   <= RST_SIDE_LO;
        end else if (i_we) begin
            unique case (t_reg_idx'(i_idx))
                REG_DEADZONE:  r_cfg.deadzone  <= i_data[DZ_W-1:0];
                REG_RAMP_STEP: r_cfg.ramp_step <= i_data[SPEED_W-1:0];
                REG_FWD_HI:    r_cfg.fwd_hi    <= i_data[SPEED_W-1:0];
                REG_FWD_LO:    r_cfg.fwd_lo    <= i_data[SPEED_W-1:0];
                REG_ROT_HI:    r_cfg.rot_hi    <= i_data[SPEED_W-1:0];
                REG_ROT_LO:    r_cfg.rot_lo    <= i_data[SPEED_W-1:0];
                REG_SIDE_HI:   r_cfg.side_hi   <= i_data[SPEED_W-1:0];
                REG_SIDE_LO:   r_cfg.side_lo   <= i_data[SPEED_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/gtcr_core.sv -----
// gtcr_core: per tick state and combinational command / ramp logic
// keeps link, button history, lift command, relays and ramped velocities;
// uses gtcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module gtcr_core #(
    parameter int VEL_WIDTH = 12
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire gtcr_pkg::t_cfg              i_cfg,
    input  wire gtcr_pkg::t_in               i_in,
    input  wire logic                        i_take,
    output gtcr_pkg::t_tick                  o_tick,
    output logic signed [VEL_WIDTH-1:0]      o_fwd,
    output logic signed [VEL_WIDTH-1:0]      o_side,
    output logic signed [VEL_WIDTH-1:0]      o_rot
);
    import gtcr_pkg::*;

    localparam int SW   = (VEL_WIDTH + 2 > SPEED_W + 2) ? VEL_WIDTH + 2 : SPEED_W + 2;
    localparam int VMAX = (1 << (VEL_WIDTH - 1)) - 1;
    localparam logic signed [SW-1:0] VMAX_E = SW'(VMAX);

    logic                        r_linked;
    logic [CMD_W-1:0]            r_last;
    logic [HIST_W-1:0]           r_hist;
    logic [RELAY_W-1:0]          r_relay;
    logic signed [VEL_WIDTH-1:0] r_fwd, r_side, r_rot;

    logic                        n_linked;
    logic [CMD_W-1:0]            n_last;
    logic [HIST_W-1:0]           n_hist;
    logic [RELAY_W-1:0]          n_relay;
    logic signed [VEL_WIDTH-1:0] n_fwd, n_side, n_rot;

    logic                        gain, lost, link, slow;
    logic [BTN_W-1:0]            b;
    logic [HIST_W-1:0]           hist_eff, now, rise;
    logic [CMD_W-1:0]            last_eff, lift;
    logic [SPEED_W-1:0]          walk, turn, slide;
    logic signed [VEL_WIDTH-1:0] tx, ty, tz;
    logic [STICK_W-1:0]          ry_abs, ly_abs;
    logic [2:0][CMD_W-1:0]       cmds;
    logic [1:0]                  ncmd;

    // saturate a speed magnitude to the velocity field and apply a sign
    function automatic logic signed [VEL_WIDTH-1:0] limit_target(
        input logic [SPEED_W-1:0] mag,
        input logic               neg
    );
        logic signed [SW-1:0] m;
        logic signed [SW-1:0] r;
        m = signed'({{(SW-SPEED_W){1'b0}}, mag});
        if (m > VMAX_E) m = VMAX_E;
        r = neg ? -m : m;
        return r[VEL_WIDTH-1:0];
    endfunction

    // move cur toward tgt by at most step
    function automatic logic signed [VEL_WIDTH-1:0] ramp(
        input logic signed [VEL_WIDTH-1:0] cur,
        input logic signed [VEL_WIDTH-1:0] tgt,
        input logic [SPEED_W-1:0]          step
    );
        logic signed [SW-1:0] c, t, s, d, r;
        c = signed'({{(SW-VEL_WIDTH){cur[VEL_WIDTH-1]}}, cur});
        t = signed'({{(SW-VEL_WIDTH){tgt[VEL_WIDTH-1]}}, tgt});
        s = signed'({{(SW-SPEED_W){1'b0}}, step});
        d = t - c;
        if (d > s)       r = c + s;
        else if (d < -s) r = c - s;
        else             r = t;
        return r[VEL_WIDTH-1:0];
    endfunction

    // link edges and effective history
    always_comb begin
        link     = i_in.link_up;
        b        = i_in.buttons;
        gain     = link & ~r_linked;
        lost     = ~link & r_linked;
        hist_eff = gain ? {HIST_W{1'b1}} : r_hist;
        last_eff = (gain | lost) ? CMD_STOP : r_last;
        slow     = b[BTN_R2];
        walk     = slow ? i_cfg.fwd_lo  : i_cfg.fwd_hi;
        turn     = slow ? i_cfg.rot_lo  : i_cfg.rot_hi;
        slide    = slow ? i_cfg.side_lo : i_cfg.side_hi;
        // history order from bit 0: square, circle, triangle, share, options
        now      = {b[BTN_OPTIONS], b[BTN_SHARE], b[BTN_TRIANGLE], b[BTN_CIRCLE],
                    b[BTN_SQUARE]};
        rise     = now & ~hist_eff;
    end

    // target velocities, first direction wins
    always_comb begin
        tx = '0;
        ty = '0;
        tz = '0;
        if (b[BTN_UP])         tx = limit_target(walk, 1'b0);
        else if (b[BTN_DOWN])  tx = limit_target(walk, 1'b1);
        if (b[BTN_LEFT])       ty = limit_target(slide, 1'b0);
        else if (b[BTN_RIGHT]) ty = limit_target(slide, 1'b1);
        if (b[BTN_L1])         tz = limit_target(turn, 1'b0);
        else if (b[BTN_R1])    tz = limit_target(turn, 1'b1);
    end

    // relay levels
    always_comb begin
        n_relay = r_relay;
        if (lost) n_relay[1] = 1'b1;
        if (link) begin
            if (rise[2]) n_relay[2] = ~n_relay[2];
            n_relay[1] = ~b[BTN_CROSS];
            if (rise[3]) n_relay[0] = ~n_relay[0];
            if (rise[4]) n_relay[3] = ~n_relay[3];
        end
    end

    // lift command from the sticks, right stick first
    always_comb begin
        ry_abs = i_in.right_stick_y[STICK_W-1] ? STICK_W'(-i_in.right_stick_y)
                                               : STICK_W'(i_in.right_stick_y);
        ly_abs = i_in.left_stick_y[STICK_W-1] ? STICK_W'(-i_in.left_stick_y)
                                              : STICK_W'(i_in.left_stick_y);
        lift = last_eff;
        priority if (ry_abs > {1'b0, i_cfg.deadzone}) begin
            if (!i_in.right_stick_y[STICK_W-1]) lift = slow ? CMD_DOWN_SLOW : CMD_DOWN_FAST;
            else                                lift = slow ? CMD_UP_SLOW : CMD_UP_FAST;
        end else if (ly_abs > {1'b0, i_cfg.deadzone}) begin
            if (!i_in.left_stick_y[STICK_W-1]) lift = slow ? CMD_OPEN_SLOW : CMD_OPEN_FAST;
            else                               lift = slow ? CMD_CLOSE_SLOW : CMD_CLOSE_FAST;
        end else if (last_eff == CMD_UP_FAST || last_eff == CMD_UP_SLOW ||
                     last_eff == CMD_DOWN_FAST || last_eff == CMD_DOWN_SLOW) begin
            lift = CMD_STOP;
        end else begin
            lift = last_eff;
        end
    end

    // command list in send order: stop, A, B, lift
    always_comb begin
        cmds = '0;
        ncmd = '0;
        if (lost) begin
            cmds[0] = CMD_STOP;
            ncmd    = 2'd1;
        end
        if (link && rise[0]) begin
            cmds[ncmd] = CMD_A;
            ncmd       = ncmd + 2'd1;
        end
        if (link && rise[1]) begin
            cmds[ncmd] = CMD_B;
            ncmd       = ncmd + 2'd1;
        end
        if (link && lift != last_eff) begin
            cmds[ncmd] = lift;
            ncmd       = ncmd + 2'd1;
        end
    end

    // next state
    always_comb begin
        n_linked = link;
        n_last   = link ? lift : last_eff;
        n_hist   = link ? now : r_hist;
        n_fwd    = link ? ramp(r_fwd, tx, i_cfg.ramp_step) : '0;
        n_side   = link ? ramp(r_side, ty, i_cfg.ramp_step) : '0;
        n_rot    = link ? ramp(r_rot, tz, i_cfg.ramp_step) : '0;
    end

    // state registers, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linked <= 1'b0;
            r_last   <= CMD_STOP;
            r_hist   <= '0;
            r_relay  <= {RELAY_W{1'b1}};
            r_fwd    <= '0;
            r_side   <= '0;
            r_rot    <= '0;
        end else if (i_take) begin
            r_linked <= n_linked;
            r_last   <= n_last;
            r_hist   <= n_hist;
            r_relay  <= n_relay;
            r_fwd    <= n_fwd;
            r_side   <= n_side;
            r_rot    <= n_rot;
        end
    end

    assign o_tick = {cmds, ncmd, n_relay};
    assign o_fwd  = n_fwd;
    assign o_side = n_side;
    assign o_rot  = n_rot;

`ifndef SYNTHESIS
    a_unlinked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_in.link_up) |=> (r_fwd == '0 && r_side == '0 && r_rot == '0))
        else $error("velocities not zero without link");
    a_link_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |=> (r_linked == $past(i_in.link_up)))
        else $error("link state does not follow the sample");
    a_lost_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && lost) |-> (ncmd == 2'd1 && cmds[0] == CMD_STOP && n_relay[1]))
        else $error("link loss did not give a single stop");
`endif

endmodule

`default_nettype wire

// ----- hdl/gtcr_out.sv -----
// gtcr_out: result register and serializer of the teleop command ramp block
// holds one tick's results and sends one per cycle while i_tready; uses gtcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module gtcr_out #(
    parameter int VEL_WIDTH = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire gtcr_pkg::t_tick              i_tick,
    input  wire logic signed [VEL_WIDTH-1:0]  i_fwd,
    input  wire logic signed [VEL_WIDTH-1:0]  i_side,
    input  wire logic signed [VEL_WIDTH-1:0]  i_rot,
    output logic                              o_free,
    output logic                              o_tvalid,
    input  wire logic                         i_tready,
    // fields from bit 0: vel_forward, vel_sideways, vel_rotate, relay_levels,
    // cmd_valid, slave_cmd, zero fill
    output logic [((3*VEL_WIDTH+13+7)/8)*8-1:0] o_tdata,
    output logic                              o_tlast
);
    import gtcr_pkg::*;

    localparam int DATA_BITS = 3 * VEL_WIDTH + RELAY_W + 1 + CMD_W;
    localparam int OUT_W     = ((DATA_BITS + 7) / 8) * 8;

    logic                        r_valid;
    logic [1:0]                  r_idx;
    t_tick                       r_tick;
    logic signed [VEL_WIDTH-1:0] r_fwd, r_side, r_rot;

    logic [1:0]       last_idx;
    logic             beat, cmd_valid;
    logic [CMD_W-1:0] slave_cmd;

    // current beat of the tick
    always_comb begin
        last_idx  = (r_tick.ncmd == 2'd0) ? 2'd0 : r_tick.ncmd - 2'd1;
        cmd_valid = (r_tick.ncmd != 2'd0);
        slave_cmd = cmd_valid ? r_tick.cmds[r_idx] : CMD_NONE;
        beat      = r_valid & i_tready;
        o_tlast   = (r_idx == last_idx);
        o_free    = ~r_valid | (beat & o_tlast);
    end

    // control: load a new tick or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (beat && o_tlast) begin
            r_valid <= 1'b0;
        end else if (beat) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tick <= i_tick;
            r_fwd  <= i_fwd;
            r_side <= i_side;
            r_rot  <= i_rot;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {{(OUT_W-DATA_BITS){1'b0}}, slave_cmd, cmd_valid, r_tick.relays,
                       r_rot, r_side, r_fwd};

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= last_idx))
        else $error("result index past the last command");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("tick loaded over undelivered results");
    a_end_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat && o_tlast && !i_load) |=> !r_valid)
        else $error("results continue after the last one");
    a_idle_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !cmd_valid) |-> (slave_cmd == CMD_NONE && o_tlast))
        else $error("command byte without a command");
`endif

endmodule

`default_nettype wire

// ----- hdl/gamepad_teleop_command_ramp_unit.sv -----
// gamepad_teleop_command_ramp_unit: top level of the teleop command ramp block
// instantiates gtcr_cfg, gtcr_core and gtcr_out; uses gtcr_pkg
//
// Usage:
//   s_axis carries one gamepad sample per control tick; m_axis returns one to
//   three results per tick, m_axis_tlast marks the final result of the tick.
//   Registers are written via i_cfg_we / i_cfg_idx / i_cfg_data on edges with
//   i_cfg_we high; users must write only while no tick is in flight (unenforced).
// Data path and rate:
//   a sample is held in an input register, the tick logic then runs
//   combinationally into the result register, which offers the first result
//   once it is free. A tick occupies the result register until its last
//   result is taken, so a new sample can be taken every cycle when each tick
//   gives a single result and m_axis_tready stays high, and otherwise only once
//   the last result of the tick is taken; the output port sends one result per
//   cycle while m_axis_tready is high.
// Reset and stall:
//   synchronous active-low reset clears link state, history, velocities, sets
//   relays to ones and registers to defaults, and empties both registers.
//   When the receiver holds m_axis_tready low the result waits, the input
//   register still takes one more sample, then s_axis_tready falls.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_teleop_command_ramp_unit #(
    parameter int VEL_WIDTH = 12
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gtcr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gtcr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // fields from bit 0: link_up, buttons, right_stick_y, left_stick_y, zero fill
    input  wire logic [gtcr_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // fields from bit 0: vel_forward, vel_sideways, vel_rotate, relay_levels,
    // cmd_valid, slave_cmd, zero fill
    output logic [((3*VEL_WIDTH+13+7)/8)*8-1:0]  m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import gtcr_pkg::*;

    t_cfg                        cfg;
    t_in                         r_in;
    logic                        r_in_valid;
    logic                        take, out_free;
    t_tick                       tick;
    logic signed [VEL_WIDTH-1:0] fwd, side, rot;

    // configuration registers
    gtcr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // input register handshake
    assign take          = r_in_valid & out_free;
    assign s_axis_tready = ~r_in_valid | take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    // tick state and logic
    gtcr_core #(.VEL_WIDTH(VEL_WIDTH)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (r_in),
        .i_take  (take),
        .o_tick  (tick),
        .o_fwd   (fwd),
        .o_side  (side),
        .o_rot   (rot)
    );

    // result register and serializer
    gtcr_out #(.VEL_WIDTH(VEL_WIDTH)) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_tick   (tick),
        .i_fwd    (fwd),
        .i_side   (side),
        .i_rot    (rot),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- dv/gamepad_teleop_command_ramp_unit_tb.sv -----
// gamepad_teleop_command_ramp_unit_tb: self-checking bench for the teleop command ramp block
// predicts per-tick commands, relay levels and ramped velocities in a scoreboard class;
// depends on gtcr_pkg and gamepad_teleop_command_ramp_unit
`timescale 1ns / 1ps

module gamepad_teleop_command_ramp_unit_tb;
    import gtcr_pkg::*;

    localparam int VEL_W        = 12;
    localparam int VEL_MAX      = (1 << (VEL_W - 1)) - 1;
    localparam int OUT_W        = ((3 * VEL_W + 13 + 7) / 8) * 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 90;

    // one expected result transaction
    typedef struct {
        logic [VEL_W-1:0]   fwd;
        logic [VEL_W-1:0]   side;
        logic [VEL_W-1:0]   rot;
        logic [RELAY_W-1:0] relays;
        logic               cmd_valid;
        logic [CMD_W-1:0]   cmd;
        logic               last;
    } t_pad_result;

    // tracks the block state and the queue of results it owes
    class command_ramp_tracker;
        int unsigned        cfg_reg [8];
        bit                 was_linked;
        logic [CMD_W-1:0]   prev_lift;
        logic [HIST_W-1:0]  hist;      // square, circle, triangle, share, options
        logic [RELAY_W-1:0] relays;
        int                 fwd;
        int                 side;
        int                 rot;
        t_pad_result        due_results [$];
        int                 errors;

        function new();
            cfg_reg[REG_DEADZONE]  = RST_DEADZONE;
            cfg_reg[REG_RAMP_STEP] = RST_RAMP_STEP;
            cfg_reg[REG_FWD_HI]    = RST_FWD_HI;
            cfg_reg[REG_FWD_LO]    = RST_FWD_LO;
            cfg_reg[REG_ROT_HI]    = RST_ROT_HI;
            cfg_reg[REG_ROT_LO]    = RST_ROT_LO;
            cfg_reg[REG_SIDE_HI]   = RST_SIDE_HI;
            cfg_reg[REG_SIDE_LO]   = RST_SIDE_LO;
            was_linked = 1'b0;
            prev_lift  = CMD_STOP;
            hist       = '0;
            relays     = '1;
            fwd        = 0;
            side       = 0;
            rot        = 0;
            errors     = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_DEADZONE)
                cfg_reg[idx] = val[DZ_W-1:0];
            else
                cfg_reg[idx] = val;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        // speed register limited to what the velocity field holds
        function int cap_speed(int unsigned mag);
            return (mag > VEL_MAX) ? VEL_MAX : int'(mag);
        endfunction

        function int ramp_toward(int cur, int tgt, int step);
            if (tgt - cur > step)
                return cur + step;
            if (tgt - cur < -step)
                return cur - step;
            return tgt;
        endfunction

        // one accepted gamepad sample
        function void take_sample(logic [IN_W-1:0] raw);
            t_in               s;
            logic [BTN_W-1:0]  b;
            logic [CMD_W-1:0]  cmds [$];
            logic [CMD_W-1:0]  lift;
            logic [HIST_W-1:0] now_b;
            logic [HIST_W-1:0] rise;
            bit                slow;
            int                ry, ly, dz, step;
            int                walk, turn, slide;
            int                tx, ty, tz;
            t_pad_result       r;

            s  = raw[IN_BITS-1:0];
            b  = s.buttons;
            ry = $signed(s.right_stick_y);
            ly = $signed(s.left_stick_y);

            // link gained: held buttons make no edge
            if (s.link_up && !was_linked) begin
                hist       = '1;
                prev_lift  = CMD_STOP;
                was_linked = 1'b1;
            end
            // link lost: stop always sent
            if (!s.link_up && was_linked) begin
                was_linked = 1'b0;
                cmds.push_back(CMD_STOP);
                prev_lift = CMD_STOP;
                relays[1] = 1'b1;
            end

            if (!s.link_up) begin
                fwd  = 0;
                side = 0;
                rot  = 0;
            end else begin
                slow  = b[BTN_R2];
                walk  = cap_speed(slow ? cfg_reg[REG_FWD_LO] : cfg_reg[REG_FWD_HI]);
                turn  = cap_speed(slow ? cfg_reg[REG_ROT_LO] : cfg_reg[REG_ROT_HI]);
                slide = cap_speed(slow ? cfg_reg[REG_SIDE_LO] : cfg_reg[REG_SIDE_HI]);
                step  = cfg_reg[REG_RAMP_STEP];
                dz    = cfg_reg[REG_DEADZONE];
                tx    = 0;
                ty    = 0;
                tz    = 0;

                // up beats down, left beats right, L1 beats R1
                if (b[BTN_UP])
                    tx = walk;
                else if (b[BTN_DOWN])
                    tx = -walk;
                if (b[BTN_LEFT])
                    ty = slide;
                else if (b[BTN_RIGHT])
                    ty = -slide;
                if (b[BTN_L1])
                    tz = turn;
                else if (b[BTN_R1])
                    tz = -turn;

                // edge detect and relay toggles
                now_b = {b[BTN_OPTIONS], b[BTN_SHARE], b[BTN_TRIANGLE], b[BTN_CIRCLE],
                         b[BTN_SQUARE]};
                rise  = now_b & ~hist;
                hist  = now_b;
                if (rise[2])
                    relays[2] = ~relays[2];
                relays[1] = ~b[BTN_CROSS];
                if (rise[3])
                    relays[0] = ~relays[0];
                if (rise[4])
                    relays[3] = ~relays[3];
                if (rise[0])
                    cmds.push_back(CMD_A);
                if (rise[1])
                    cmds.push_back(CMD_B);

                // right stick first, then left, else up/down falls back to stop
                lift = prev_lift;
                if ((ry < 0 ? -ry : ry) > dz)
                    lift = (ry > 0) ? (slow ? CMD_DOWN_SLOW : CMD_DOWN_FAST)
                                    : (slow ? CMD_UP_SLOW : CMD_UP_FAST);
                else if ((ly < 0 ? -ly : ly) > dz)
                    lift = (ly > 0) ? (slow ? CMD_OPEN_SLOW : CMD_OPEN_FAST)
                                    : (slow ? CMD_CLOSE_SLOW : CMD_CLOSE_FAST);
                else if (prev_lift inside {CMD_UP_FAST, CMD_UP_SLOW,
                                           CMD_DOWN_FAST, CMD_DOWN_SLOW})
                    lift = CMD_STOP;
                if (lift != prev_lift) begin
                    if (cmds.size() < 3)
                        cmds.push_back(lift);
                    prev_lift = lift;
                end

                fwd  = ramp_toward(fwd, tx, step);
                side = ramp_toward(side, ty, step);
                rot  = ramp_toward(rot, tz, step);
            end

            // every result of the tick shares velocities and relays
            r.fwd    = fwd[VEL_W-1:0];
            r.side   = side[VEL_W-1:0];
            r.rot    = rot[VEL_W-1:0];
            r.relays = relays;
            if (cmds.size() == 0) begin
                r.cmd_valid = 1'b0;
                r.cmd       = CMD_NONE;
                r.last      = 1'b1;
                due_results.push_back(r);
            end else begin
                foreach (cmds[k]) begin
                    r.cmd_valid = 1'b1;
                    r.cmd       = cmds[k];
                    r.last      = (k == cmds.size() - 1);
                    due_results.push_back(r);
                end
            end
        endfunction

        function void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
            if (exp_v !== got_v) begin
                errors++;
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, exp_v, got_v);
            end
        endfunction

        // one accepted result transaction
        function void match_result(logic [OUT_W-1:0] d, logic last);
            t_pad_result e;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual data 0x%0h last %0b",
                         $time, d, last);
                return;
            end
            e = due_results.pop_front();
            check_field("vel_forward", e.fwd, d[VEL_W-1:0]);
            check_field("vel_sideways", e.side, d[2*VEL_W-1:VEL_W]);
            check_field("vel_rotate", e.rot, d[3*VEL_W-1:2*VEL_W]);
            check_field("relay_levels", e.relays, d[3*VEL_W+3:3*VEL_W]);
            check_field("cmd_valid", e.cmd_valid, d[3*VEL_W+4]);
            check_field("slave_cmd", e.cmd, d[3*VEL_W+12:3*VEL_W+5]);
            check_field("last_of_tick", e.last, last);
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;

    command_ramp_tracker tracker = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int stall_cycles  = 0;

    gamepad_teleop_command_ramp_unit #(
        .VEL_WIDTH(VEL_W)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // transaction monitor and no-progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            tracker.take_sample(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_result(m_axis_tdata, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("gamepad_teleop_command_ramp_unit_tb: done, errors");
            $finish;
        end
    end

    // receiver: random backpressure plus long hold-offs on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic t_in make_sample(logic link, logic [BTN_W-1:0] b, int ry, int ly);
        t_in s;
        s.link_up       = link;
        s.buttons       = b;
        s.right_stick_y = ry[STICK_W-1:0];
        s.left_stick_y  = ly[STICK_W-1:0];
        return s;
    endfunction

    // stick values weighted toward zero, the deadzone border and the ends
    function automatic logic [STICK_W-1:0] stick_pick(int dz);
        int v;
        case ($urandom_range(0, 4))
            0: v = 0;
            1: v = $urandom_range(0, 1) ? dz + int'($urandom_range(0, 1))
                                        : -dz - int'($urandom_range(0, 1));
            2: v = $urandom_range(0, 1) ? 127 : -128;
            3: v = int'($urandom_range(0, 2 * dz)) - dz;
            default: v = int'($urandom_range(0, 255)) - 128;
        endcase
        if (v > 127)
            v = 127;
        return v[STICK_W-1:0];
    endfunction

    // mostly linked ticks with held, toggled or fresh button masks
    function automatic t_in random_sample(logic [BTN_W-1:0] prev, int dz);
        t_in s;
        s.link_up = ($urandom_range(0, 99) < 90);
        case ($urandom_range(0, 4))
            0: s.buttons = prev;
            1, 2: s.buttons = prev ^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1));
            default: s.buttons = BTN_W'($urandom_range(0, (1 << BTN_W) - 1));
        endcase
        s.right_stick_y = stick_pick(dz);
        s.left_stick_y  = stick_pick(dz);
        return s;
    endfunction

    task automatic offer_sample(input t_in smp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - IN_BITS){1'b0}}, smp};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register writes only while nothing is in flight
    task automatic set_registers(input logic [CFG_DATA_W-1:0] vals [8]);
        t_reg_idx ri;
        ri = ri.first();
        repeat (8) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= ri;
            i_cfg_data <= vals[ri];
            tracker.write_reg(ri, vals[ri]);
            @(posedge i_clk);
            ri = ri.next();
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int hold_at);
        t_in              smp;
        logic [BTN_W-1:0] prev;
        prev = '0;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_requests++;
            smp  = random_sample(prev, tracker.cfg_reg[REG_DEADZONE]);
            prev = smp.buttons;
            offer_sample(smp);
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] regs [8];
        logic [BTN_W-1:0]      drive_neg;
        logic [BTN_W-1:0]      drive_pos;

        drive_neg = (BTN_W'(1) << BTN_DOWN) | (BTN_W'(1) << BTN_RIGHT) | (BTN_W'(1) << BTN_R1);
        drive_pos = (BTN_W'(1) << BTN_UP) | (BTN_W'(1) << BTN_LEFT) | (BTN_W'(1) << BTN_L1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed ticks at reset settings
        send_idle_pct = 32;
        recv_idle_pct = 68;
        offer_sample(make_sample(1'b0, '0, 0, 0));
        offer_sample(make_sample(1'b0, '1, 127, -128));
        // link gained with every button held, slow lift up
        offer_sample(make_sample(1'b1, '1, -128, 0));
        offer_sample(make_sample(1'b1, '0, 0, 0));
        // square and circle edges plus lift down: three results
        offer_sample(make_sample(1'b1, (BTN_W'(1) << BTN_SQUARE) | (BTN_W'(1) << BTN_CIRCLE),
                                 127, 0));
        offer_sample(make_sample(1'b1, (BTN_W'(1) << BTN_TRIANGLE) | (BTN_W'(1) << BTN_SHARE)
                                 | (BTN_W'(1) << BTN_OPTIONS) | (BTN_W'(1) << BTN_CROSS),
                                 100, 127));
        // open command survives the deadzone
        offer_sample(make_sample(1'b1, '0, 0, 0));
        offer_sample(make_sample(1'b1, BTN_W'(1) << BTN_R2, -100, -101));
        // right stick wins over left stick
        offer_sample(make_sample(1'b1, '0, 101, -128));
        offer_sample(make_sample(1'b1, drive_neg, 0, 0));
        offer_sample(make_sample(1'b1, drive_neg, 0, 0));
        offer_sample(make_sample(1'b1, drive_pos | drive_neg | (BTN_W'(1) << BTN_R2), 0, 127));
        offer_sample(make_sample(1'b0, '0, 0, 0));
        offer_sample(make_sample(1'b1, BTN_W'(1) << BTN_SQUARE, 0, 0));
        offer_sample(make_sample(1'b1, '0, 0, 0));
        offer_sample(make_sample(1'b1, BTN_W'(1) << BTN_SQUARE, -101, 0));
        offer_sample(make_sample(1'b0, '1, 0, 0));
        offer_sample(make_sample(1'b1, '0, 0, 0));
        // link lost while the last lift was already stop
        offer_sample(make_sample(1'b0, '0, 0, 0));
        offer_sample(make_sample(1'b1, drive_pos, 0, 0));
        offer_sample(make_sample(1'b1, drive_pos, 0, 0));
        drain_results();

        // random settings, long receiver hold-off early on
        foreach (regs[r])
            regs[r] = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
        regs[REG_RAMP_STEP] = CFG_DATA_W'($urandom_range(1, 400));
        set_registers(regs);
        run_random(80, 10);
        drain_results();

        // all registers at their largest value
        send_idle_pct = 68;
        recv_idle_pct = 32;
        foreach (regs[r])
            regs[r] = '1;
        set_registers(regs);
        run_random(80, -1);
        drain_results();

        // all registers zero, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (regs[r])
            regs[r] = '0;
        set_registers(regs);
        run_random(40, -1);
        drain_results();

        foreach (regs[r])
            regs[r] = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
        regs[REG_RAMP_STEP] = CFG_DATA_W'($urandom_range(1, 400));
        set_registers(regs);
        run_random(50, -1);
        drain_results();

        if (tracker.errors == 0)
            $display("gamepad_teleop_command_ramp_unit_tb: done, clean");
        else
            $display("gamepad_teleop_command_ramp_unit_tb: done, errors");
        $finish;
    end

endmodule
